// ===== rtl/stable_priority_queue_assert.svh =====
// Assertion macros for the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Package with types and constants of the stable priority queue.
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ID_W     = 16;
    localparam int PRI_W    = 8;
    localparam int BURST_W  = 16;
    localparam int WAIT_W   = 5;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 48;
    localparam int OUT_UW   = 3;

    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_SERVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted shift-register queue.
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_slot      i_left,
    input  logic       i_left_gt,
    input  t_slot      i_right,
    output t_slot      o_slot,
    output logic       o_gt
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;

    // New entry belongs at or before this slot: empty or strictly larger priority.
    assign o_gt = !r_valid || (r_entry.pri > i_new.pri);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end else if (i_ctrl.insert && o_gt) begin
            if (i_left_gt) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.entry = r_entry;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: a chain of sorted slot cells.
//
// Input stream (s_axis): tuser[0] is the kind (0 add, 1 serve); tdata carries
// task_id, priority_req and burst_time. Every input transaction gives exactly
// one output transaction on m_axis with the served entry, the number of
// entries still waiting and a status code (ok, serve on empty, add on full).
// Adds insert in sorted position; equal priorities keep arrival order. An add
// on a full queue is dropped; a serve on an empty queue returns zeros.
// The result is registered: output valid rises in the cycle after the input
// transaction. One item per cycle is sustained while the receiver takes each
// result: all cells compare against the new priority at once and shift one
// slot in the same cycle. When the receiver stalls, the result holds in the
// output register and s_axis_tready drops until it is taken; a new item is
// accepted in the same cycle the held result leaves.
// Synchronous active-low reset empties the queue (all slot valid bits clear)
// and drops any pending result; no clearing pass is needed.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] task_id, [23:16] priority_req, [39:24] burst_time
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // [0] kind
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] served_id, [23:16] served_priority, [39:24] served_burst,
    // [44:40] waiting_count, [47:45] zero
    output logic [OUT_DW-1:0] m_axis_tdata,
    // [0] served_valid, [2:1] status
    output logic [OUT_UW-1:0] m_axis_tuser
);

    t_entry             w_new;
    t_kind              w_kind;
    t_cell_ctrl         w_ctrl;
    t_slot              w_slot [DEPTH];
    logic [DEPTH-1:0]   w_gt;
    logic [DEPTH-1:0]   w_valid;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [OUT_DW-1:0]  r_out_data;
    logic [OUT_DW-1:0]  n_out_data;
    logic [OUT_UW-1:0]  r_out_user;
    logic [OUT_UW-1:0]  n_out_user;

    assign w_new.id    = s_axis_tdata[15:0];
    assign w_new.pri   = s_axis_tdata[23:16];
    assign w_new.burst = s_axis_tdata[39:24];
    assign w_kind      = t_kind'(s_axis_tuser);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    assign w_ctrl.insert = w_accept && (w_kind == KIND_ADD) && !w_full;
    assign w_ctrl.pop    = w_accept && (w_kind == KIND_SERVE) && !w_empty;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_gt;

        if (gi == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_slot[gi-1];
            assign w_left_gt = w_gt[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[gi+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_slot    (w_slot[gi]),
            .o_gt      (w_gt[gi])
        );

        assign w_valid[gi] = w_slot[gi].valid;
    end

    always_comb begin
        t_status v_status;
        logic    v_served;

        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        v_status    = ST_OK;
        v_served    = 1'b0;

        if (w_ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            if (w_kind == KIND_SERVE) begin
                v_served = !w_empty;
                if (w_empty) begin
                    v_status = ST_EMPTY;
                end
            end else if (w_full) begin
                v_status = ST_FULL;
            end
            n_out_valid = 1'b1;
            n_out_data  = '0;
            if (v_served) begin
                n_out_data[15:0]  = w_slot[0].entry.id;
                n_out_data[23:16] = w_slot[0].entry.pri;
                n_out_data[39:24] = w_slot[0].entry.burst;
            end
            n_out_data[44:40] = WAIT_W'(n_count);
            n_out_user        = {v_status, v_served};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`include "stable_priority_queue_assert.svh"

    // Occupancy counter tracks the valid bits held in the cells.
    `SPQ_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(w_valid) == int'(r_count))
    // Valid slots form a contiguous run from the head.
    `SPQ_ASSERT_IMP(a_valid_packed, i_clk, i_rst_n, 1'b1, ((w_valid + 1'b1) & w_valid) == '0)
    // Add on a full queue reports full and leaves the count alone.
    `SPQ_ASSERT_NXT(a_full_drop, i_clk, i_rst_n, w_accept && (w_kind == KIND_ADD) && w_full, (m_axis_tuser[2:1] == ST_FULL) && (r_count == CNT_W'(DEPTH)))
    // Serve on a nonempty queue removes exactly one entry.
    `SPQ_ASSERT_NXT(a_serve_dec, i_clk, i_rst_n, w_ctrl.pop, (r_count == $past(r_count) - CNT_W'(1)) && m_axis_tuser[0])

endmodule

// ===== tb/stable_priority_queue_check.sv =====
// Checker for the stable priority queue: predicts every result and compares it.
`timescale 1ns / 100ps

module stable_priority_queue_check
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IN_DW-1:0]  i_in_data,
    input  logic              i_in_user,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [OUT_DW-1:0] i_out_data,
    input  logic [OUT_UW-1:0] i_out_user,
    output int                o_errors,
    output int                o_outstanding
);

    typedef struct packed {
        logic              served;
        t_entry            entry;
        logic [WAIT_W-1:0] waiting;
        t_status           status;
    } t_reply;

    // predicted queue contents, slot 0 is the next one served
    t_entry      order_q [DEPTH];
    int unsigned fill = 0;
    t_reply      reply_fifo [$];
    int          errors = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < 40) begin
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    // Applies one transaction to the predicted queue and returns its result.
    function automatic t_reply advance_queue(t_kind kind, t_entry item);
        t_reply r;
        int     pos;
        int     i;
        r = '0;
        r.status = ST_OK;
        if (kind == KIND_SERVE) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.served = 1'b1;
                r.entry  = order_q[0];
                for (i = 0; i + 1 < fill; i++) order_q[i] = order_q[i+1];
                fill--;
            end
        end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // after every entry of equal or better priority: ties keep arrival order
            pos = 0;
            while (pos < fill && order_q[pos].pri <= item.pri) pos++;
            for (i = fill; i > pos; i--) order_q[i] = order_q[i-1];
            order_q[pos] = item;
            fill++;
        end
        r.waiting = WAIT_W'(fill);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_entry item;
        if (!i_rst_n) begin
            fill = 0;
            reply_fifo.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reply_fifo.size() == 0) begin
                    report_mismatch("result with no transaction pending", i_out_data[31:0], 0);
                end else begin
                    want = reply_fifo.pop_front();
                    if (i_out_user[0] != want.served)
                        report_mismatch("served_valid", 32'(i_out_user[0]), 32'(want.served));
                    if (i_out_user[2:1] != want.status)
                        report_mismatch("status", 32'(i_out_user[2:1]), 32'(want.status));
                    if (i_out_data[15:0] != want.entry.id)
                        report_mismatch("served_id", 32'(i_out_data[15:0]),
                                        32'(want.entry.id));
                    if (i_out_data[23:16] != want.entry.pri)
                        report_mismatch("served_priority", 32'(i_out_data[23:16]),
                                        32'(want.entry.pri));
                    if (i_out_data[39:24] != want.entry.burst)
                        report_mismatch("served_burst", 32'(i_out_data[39:24]),
                                        32'(want.entry.burst));
                    if (i_out_data[44:40] != want.waiting)
                        report_mismatch("waiting_count", 32'(i_out_data[44:40]),
                                        32'(want.waiting));
                    if (i_out_data[47:45] != 3'b000)
                        report_mismatch("tdata padding", 32'(i_out_data[47:45]), 0);
                end
            end
            if (i_in_valid && i_in_ready) begin
                item.id    = i_in_data[15:0];
                item.pri   = i_in_data[23:16];
                item.burst = i_in_data[39:24];
                reply_fifo.push_back(advance_queue(t_kind'(i_in_user), item));
            end
        end
        o_errors      <= errors;
        o_outstanding <= reply_fifo.size();
    end

endmodule

// ===== tb/stable_priority_queue_test.sv =====
// Testbench top for the stable priority queue: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module stable_priority_queue_test;
    import spq_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] id;
        logic [7:0]  pri;
        logic [15:0] burst;
    } t_job;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [OUT_UW-1:0] m_axis_tuser;

    int errors;
    int outstanding;
    int burst_left = 0;
    int n_adds = 0;
    int n_serves = 0;

    always #1 i_clk = ~i_clk;

    stable_priority_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    stable_priority_queue_check i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // Offers one transaction and returns at the edge that takes it.
    task automatic offer_job(t_job job);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= job.kind;
        s_axis_tdata  <= {job.burst, job.pri, job.id};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (job.kind == KIND_ADD) n_adds++;
        else n_serves++;
    endtask

    function automatic t_job make_job(t_kind kind, logic [15:0] id, logic [7:0] pri,
                                      logic [15:0] burst);
        t_job job;
        job.kind  = kind;
        job.id    = id;
        job.pri   = pri;
        job.burst = burst;
        return job;
    endfunction

    // Random job; add_pct biases toward filling or draining the queue.
    function automatic t_job random_job(int add_pct);
        logic [7:0] pri;
        case ($urandom_range(0, 3))
            0: pri = 8'($urandom_range(0, 255));
            1: pri = 8'($urandom_range(0, 3));
            2: pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pri = 8'($urandom_range(100, 110));
        endcase
        return make_job(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_SERVE,
                        16'($urandom), pri, 16'($urandom));
    endfunction

    // Receiver: stall modes of varying density, with two long hold-offs.
    initial begin
        int mode;
        int len;
        int round;
        round = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 40);
            repeat (len) begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
            round++;
            if (round == 4 || round == 20) begin
                // queue output backs up and s_axis_tready must drop
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [7:0] tie_pris [14];
        int seg;
        int add_pct;
        tie_pris = '{8'd7, 8'd7, 8'd7, 8'd7, 8'd3, 8'd200, 8'd7, 8'd0,
                     8'd128, 8'd1, 8'd254, 8'd7, 8'd64, 8'd255};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty serve, field extremes, ties, fill to full, overflow, partial drain
        offer_job(make_job(KIND_SERVE, 16'h0000, 8'h00, 16'h0000));
        offer_job(make_job(KIND_ADD, 16'hFFFF, 8'hFF, 16'hFFFF));
        offer_job(make_job(KIND_ADD, 16'h0000, 8'h00, 16'h0000));
        foreach (tie_pris[k])
            offer_job(make_job(KIND_ADD, 16'h1000 + 16'(k), tie_pris[k], 16'($urandom)));
        offer_job(make_job(KIND_ADD, 16'hAAAA, 8'h00, 16'h5555));
        repeat (6) offer_job(make_job(KIND_SERVE, 16'($urandom), 8'($urandom), 16'($urandom)));

        for (seg = 0; seg < 15; seg++) begin
            case ($urandom_range(0, 3))
                0: add_pct = 85;
                1: add_pct = 20;
                2: add_pct = 55;
                default: add_pct = 50;
            endcase
            repeat (30) offer_job(random_job(add_pct));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d transactions: %0d adds and %0d serves, with ties, full and",
                 n_adds + n_serves, n_adds, n_serves);
        $display("empty queue cases, bursty input and long output back-pressure");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
